### hw/rtl/arm_instruction_field_decode_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the instruction field decoder
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ARM_INSTRUCTION_FIELD_DECODE_MACROS_SVH
`define ARM_INSTRUCTION_FIELD_DECODE_MACROS_SVH
`ifndef SYNTHESIS
`define AIFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aifd assertion failed");
`define AIFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aifd assertion failed");
`else
`define AIFD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AIFD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/aifd_pkg.sv
// ---------------------------------------------------------------------------
// Instruction field decoder package
// Types, codes and widths shared by the decoder modules.
// ---------------------------------------------------------------------------
package aifd_pkg;

    localparam int WORD_W   = 32;
    localparam int AMT_W    = 8;
    localparam int IN_W     = 96;
    localparam int OUT_W    = 64;
    localparam int OUT_USED = 63;

    typedef enum logic [2:0] {
        KIND_PROC    = 3'd0,
        KIND_MUL     = 3'd1,
        KIND_XFER    = 3'd2,
        KIND_BRANCH  = 3'd3,
        KIND_HALT    = 3'd4,
        KIND_INVALID = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  cond_code;
        logic [3:0]  alu_opcode;
        logic [5:0]  flag_bits;
        logic [3:0]  base_reg;
        logic [3:0]  dest_reg;
        logic [3:0]  index_reg;
        logic [3:0]  shift_reg;
        logic [31:0] operand;
        logic        carry_out;
    } result_t;

endpackage

### hw/rtl/aifd_barrel.sv
// ---------------------------------------------------------------------------
// Barrel shifter
// LSL, LSR, ASR and ROR of a word by an 8-bit amount, with carry out.
// ---------------------------------------------------------------------------
module aifd_barrel
    import aifd_pkg::*;
(
    input  logic [WORD_W-1:0] value,
    input  shift_t            kind,
    input  logic [AMT_W-1:0]  amount,
    output logic [WORD_W-1:0] result,
    output logic              carry
);

    logic [4:0]          amt_lo;
    logic                amt_big;
    logic                amt_32;
    logic                sign;
    logic [WORD_W:0]     lsl_ext;
    logic [WORD_W:0]     lsr_ext;
    logic [WORD_W:0]     asr_ext;
    logic [2*WORD_W-1:0] ror_ext;

    assign amt_lo  = amount[4:0];
    assign amt_big = |amount[AMT_W-1:5];
    assign amt_32  = (amount == AMT_W'(32));
    assign sign    = value[WORD_W-1];
    assign lsl_ext = {1'b0, value} << amt_lo;
    assign lsr_ext = {value, 1'b0} >> amt_lo;
    assign asr_ext = $unsigned($signed({value, 1'b0}) >>> amt_lo);
    assign ror_ext = {value, value} >> amt_lo;

    always_comb
    begin
        result = value;
        carry  = 1'b0;
        if (amount != '0)
        begin
            case (kind)
                SHIFT_LSL:
                begin
                    if (!amt_big)
                    begin
                        result = lsl_ext[WORD_W-1:0];
                        carry  = lsl_ext[WORD_W];
                    end
                    else
                    begin
                        result = '0;
                        carry  = amt_32 ? value[0] : 1'b0;
                    end
                end
                SHIFT_LSR:
                begin
                    if (!amt_big)
                    begin
                        result = lsr_ext[WORD_W:1];
                        carry  = lsr_ext[0];
                    end
                    else
                    begin
                        result = '0;
                        carry  = amt_32 ? sign : 1'b0;
                    end
                end
                SHIFT_ASR:
                begin
                    if (!amt_big)
                    begin
                        result = asr_ext[WORD_W:1];
                        carry  = asr_ext[0];
                    end
                    else
                    begin
                        result = {WORD_W{sign}};
                        carry  = sign;
                    end
                end
                SHIFT_ROR:
                begin
                    result = ror_ext[WORD_W-1:0];
                    carry  = ror_ext[WORD_W-1];
                end
                default:
                begin
                    result = value;
                    carry  = 1'b0;
                end
            endcase
        end
    end

endmodule

### hw/rtl/aifd_decode.sv
// ---------------------------------------------------------------------------
// Instruction field decode
// Classifies the word, unpacks its fields and forms operand2 or the offset.
// ---------------------------------------------------------------------------
module aifd_decode
    import aifd_pkg::*;
(
    input  logic [WORD_W-1:0] instr,
    input  logic [WORD_W-1:0] rm_value,
    input  logic [WORD_W-1:0] rs_value,
    output result_t           res
);

    kind_t               kind;
    logic                ibit;
    logic                sbit;
    logic                shifted_reg;
    logic [AMT_W-1:0]    amount;
    logic [WORD_W-1:0]   shift_result;
    logic                shift_carry;
    logic [4:0]          rot;
    logic [2*WORD_W-1:0] imm_ext;

    assign ibit = instr[25];
    assign sbit = instr[20];

    always_comb
    begin
        if (instr == '0)
            kind = KIND_HALT;
        else if (instr[27:26] == 2'b01)
            kind = KIND_XFER;
        else if (instr[27:24] == 4'hA)
            kind = KIND_BRANCH;
        else if (instr[27:26] == 2'b00)
            kind = ((instr[27:22] == 6'd0) && (instr[7:4] == 4'h9)) ? KIND_MUL : KIND_PROC;
        else
            kind = KIND_INVALID;
    end

    assign shifted_reg = ((kind == KIND_PROC) && !ibit) || ((kind == KIND_XFER) && ibit);
    assign amount      = instr[4] ? rs_value[AMT_W-1:0] : {3'b000, instr[11:7]};
    assign rot         = {instr[11:8], 1'b0};
    assign imm_ext     = {24'd0, instr[7:0], 24'd0, instr[7:0]} >> rot;

    aifd_barrel u_barrel (
        .value  (rm_value),
        .kind   (shift_t'(instr[6:5])),
        .amount (amount),
        .result (shift_result),
        .carry  (shift_carry)
    );

    always_comb
    begin
        res            = '0;
        res.kind       = kind;
        res.cond_code  = instr[31:28];
        case (kind)
            KIND_MUL:
            begin
                res.flag_bits = {4'b0000, sbit, instr[21]};
                res.dest_reg  = instr[19:16];
                res.base_reg  = instr[15:12];
                res.shift_reg = instr[11:8];
                res.index_reg = instr[3:0];
            end
            KIND_BRANCH:
            begin
                res.operand = {8'd0, instr[23:0]};
            end
            KIND_PROC, KIND_XFER:
            begin
                res.base_reg = instr[19:16];
                res.dest_reg = instr[15:12];
                if (kind == KIND_PROC)
                begin
                    res.alu_opcode = instr[24:21];
                    res.flag_bits  = {3'b000, ibit, sbit, 1'b0};
                end
                else
                begin
                    res.flag_bits = {sbit, instr[23], instr[24], ibit, 2'b00};
                end
                if (shifted_reg)
                begin
                    res.index_reg = instr[3:0];
                    res.shift_reg = instr[4] ? instr[11:8] : 4'd0;
                    res.operand   = shift_result;
                    res.carry_out = shift_carry;
                end
                else if (kind == KIND_PROC)
                begin
                    res.operand   = imm_ext[WORD_W-1:0];
                    res.carry_out = (rot != 5'd0) && imm_ext[WORD_W-1];
                end
                else
                begin
                    res.operand = {20'd0, instr[11:0]};
                end
            end
            default:
            begin
                res.operand = '0;
            end
        endcase
    end

endmodule

### hw/rtl/arm_instruction_field_decode.sv
// ---------------------------------------------------------------------------
// Instruction field decoder, top level
// Input register, decode and barrel shifter, result register.
// ---------------------------------------------------------------------------
// The slave channel takes one transaction per instruction: the word and the
// values of the registers it names in bits 3..0 and 11..8. The master channel
// gives one transaction per instruction with the kind in tuser and the
// decoded fields and operand in tdata, in the order of the input.
// An accepted transaction is held in the input register, decoded from there
// and presented from the result register. Throughput is one instruction per
// cycle while the receiver does not stall; the decode path through the
// barrel shifter sits between the two registers and sets the cycle time.
// While the receiver stalls, the result register holds its transaction and
// the input register can still take one more; after that s_tready falls
// until the result is taken. Reset empties both registers; no transaction
// is lost or repeated.
// ---------------------------------------------------------------------------
`include "arm_instruction_field_decode_macros.svh"

module arm_instruction_field_decode
    import aifd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // instr, rm_value, rs_value
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // cond_code, alu_opcode, flag_bits, base_reg, dest_reg, index_reg,
    // shift_reg, operand, carry_out, zero padding
    output logic [OUT_W-1:0] m_tdata,
    // instr_kind
    output logic [2:0]       m_tuser
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [WORD_W-1:0] instr_reg;
    logic [WORD_W-1:0] rm_reg;
    logic [WORD_W-1:0] rs_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           dec_res;
    logic              advance;
    logic              take_in;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = take_in || (in_valid_reg && !advance);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            instr_reg <= s_tdata[31:0];
            rm_reg    <= s_tdata[63:32];
            rs_reg    <= s_tdata[95:64];
        end
        if (advance && in_valid_reg)
            out_reg <= dec_res;
    end

    aifd_decode u_decode (
        .instr    (instr_reg),
        .rm_value (rm_reg),
        .rs_value (rs_reg),
        .res      (dec_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {{(OUT_W-OUT_USED){1'b0}}, out_reg.carry_out, out_reg.operand,
                       out_reg.shift_reg, out_reg.index_reg, out_reg.dest_reg,
                       out_reg.base_reg, out_reg.flag_bits, out_reg.alu_opcode,
                       out_reg.cond_code};

    `AIFD_ASSERT_NXT(a_take_fills, clk, rst_n, take_in, in_valid_reg)
    `AIFD_ASSERT_NXT(a_move_fills, clk, rst_n, in_valid_reg && advance, m_tvalid)
    `AIFD_ASSERT_NXT(a_hold_input, clk, rst_n, in_valid_reg && !advance,
                     in_valid_reg && $stable(instr_reg))
    `AIFD_ASSERT_IMP(a_halt_empty, clk, rst_n, m_tvalid && (out_reg.kind == KIND_HALT),
                     (out_reg.operand == '0) && (out_reg.flag_bits == '0))

endmodule
